@@ design/gpr_pkg.sv @@
// Package for the GPIO port register block: word types, register indexes,
// pin constants and the per-pin mask spreading functions.
// No dependencies.
package gpr_pkg;

    localparam int unsigned PORT_WIDTH = 16;
    localparam int unsigned PIN_COUNT  = 16;  // 1..16 pins in use

    // Pins at or above PIN_COUNT read zero and cannot be written
    localparam logic [PORT_WIDTH-1:0] VALID_MASK =
        PORT_WIDTH'((32'd1 << PIN_COUNT) - 32'd1);

    // Bus access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register indexes
    localparam logic [3:0] REG_MODE     = 4'd0;
    localparam logic [3:0] REG_OTYPE    = 4'd1;
    localparam logic [3:0] REG_SPEED    = 4'd2;
    localparam logic [3:0] REG_PULL     = 4'd3;
    localparam logic [3:0] REG_INDATA   = 4'd4;
    localparam logic [3:0] REG_OUTDATA  = 4'd5;
    localparam logic [3:0] REG_SETRESET = 4'd6;
    localparam logic [3:0] REG_LOCK     = 4'd7;
    localparam logic [3:0] REG_AFL      = 4'd8;
    localparam logic [3:0] REG_AFH      = 4'd9;

    // Bit that carries the lock key in a lock register word
    localparam int unsigned LOCK_KEY_BIT = 16;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] output_levels;
        logic        lock_active;
    } t_out_word;

    // Access handed to the lock sequencer
    typedef struct packed {
        logic                  go;     // access taken this cycle
        logic                  write;
        logic                  hit;    // access targets the lock register
        logic                  key;
        logic [PORT_WIDTH-1:0] mask;
    } t_lock_req;

    // Lock status back to the register file
    typedef struct packed {
        logic                  key;
        logic                  key_next;
        logic [PORT_WIDTH-1:0] mask;
    } t_lock_stat;

    function automatic logic [2*PORT_WIDTH-1:0] spread2(input logic [PORT_WIDTH-1:0] pins);
        logic [2*PORT_WIDTH-1:0] m;
        m = '0;
        for (int i = 0; i < PORT_WIDTH; i++) begin
            m[2*i +: 2] = {2{pins[i]}};
        end
        return m;
    endfunction

    function automatic logic [4*PORT_WIDTH-1:0] spread4(input logic [PORT_WIDTH-1:0] pins);
        logic [4*PORT_WIDTH-1:0] m;
        m = '0;
        for (int i = 0; i < PORT_WIDTH; i++) begin
            m[4*i +: 4] = {4{pins[i]}};
        end
        return m;
    endfunction

endpackage

@@ design/gpr_lock.sv @@
// Lock key sequencer: tracks the key write/write/write/read sequence and
// holds the lock key and lock mask. Depends on gpr_pkg.
module gpr_lock (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gpr_pkg::t_lock_req i_req,
    output gpr_pkg::t_lock_stat o_stat
);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_KEY1,
        SEQ_KEY0,
        SEQ_KEY2
    } t_seq;

    t_seq                           r_step, n_step;
    logic                           r_key, n_key;
    logic [gpr_pkg::PORT_WIDTH-1:0] r_mask, n_mask;
    logic                           same;

    assign same = (i_req.mask == r_mask);

    always_comb begin
        n_step = r_step;
        n_key  = r_key;
        n_mask = r_mask;
        if (i_req.go) begin
            if (!i_req.hit) begin
                // any other register breaks the sequence
                n_step = SEQ_IDLE;
            end else if (i_req.write) begin
                if (!r_key) begin
                    if (r_step == SEQ_KEY1 && !i_req.key && same) begin
                        n_step = SEQ_KEY0;
                    end else if (r_step == SEQ_KEY0 && i_req.key && same) begin
                        n_step = SEQ_KEY2;
                    end else begin
                        // restart; a key=1 write counts as a new first step
                        n_mask = i_req.mask;
                        n_step = i_req.key ? SEQ_KEY1 : SEQ_IDLE;
                    end
                end
            end else begin
                if (r_step == SEQ_KEY2) begin
                    n_key = 1'b1;
                end
                n_step = SEQ_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SEQ_IDLE;
            r_key  <= 1'b0;
            r_mask <= '0;
        end else begin
            r_step <= n_step;
            r_key  <= n_key;
            r_mask <= n_mask;
        end
    end

    assign o_stat.key      = r_key;
    assign o_stat.key_next = n_key;
    assign o_stat.mask     = r_mask;

`ifndef SYNTHESIS
    a_key_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key |=> r_key && $stable(r_mask))
        else $error("lock key dropped or mask changed after lock");

    a_key_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_key) |-> $past(r_step) == SEQ_KEY2 && $past(i_req.go)
                         && $past(i_req.hit) && !$past(i_req.write))
        else $error("lock key set outside a completed sequence");

    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == SEQ_KEY2 |-> $past(r_step) == SEQ_KEY0 || $past(r_step) == SEQ_KEY2)
        else $error("third key step reached out of order");
`endif

endmodule

@@ design/gpr_regs.sv @@
// Pin configuration and output data registers with write masking by the
// lock, plus the read mux. Depends on gpr_pkg.
module gpr_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  gpr_pkg::t_in_word               i_word,
    input  gpr_pkg::t_lock_stat             i_lock,
    output logic [31:0]                     o_read_data,
    output logic [gpr_pkg::PORT_WIDTH-1:0]  o_out_data_next
);

    logic [31:0]                    r_mode, r_speed, r_pull, r_afl, r_afh;
    logic [gpr_pkg::PORT_WIDTH-1:0] r_otype, r_odata;
    logic [31:0]                    n_mode, n_speed, n_pull, n_afl, n_afh;
    logic [gpr_pkg::PORT_WIDTH-1:0] n_otype, n_odata;

    logic [gpr_pkg::PORT_WIDTH-1:0]   freep;
    logic [2*gpr_pkg::PORT_WIDTH-1:0] m2;
    logic [4*gpr_pkg::PORT_WIDTH-1:0] m4;
    logic [31:0]                      wd;
    logic                             wr;

    assign wd    = i_word.write_data;
    assign wr    = i_go && (i_word.cmd == gpr_pkg::CMD_WRITE);
    assign freep = gpr_pkg::VALID_MASK & ~(i_lock.key ? i_lock.mask : '0);
    assign m2    = gpr_pkg::spread2(freep);
    assign m4    = gpr_pkg::spread4(freep);

    always_comb begin
        n_mode  = r_mode;
        n_otype = r_otype;
        n_speed = r_speed;
        n_pull  = r_pull;
        n_afl   = r_afl;
        n_afh   = r_afh;
        n_odata = r_odata;
        if (wr) begin
            unique case (i_word.reg_index)
                gpr_pkg::REG_MODE:    n_mode  = (r_mode & ~m2) | (wd & m2);
                gpr_pkg::REG_OTYPE:   n_otype = (r_otype & ~freep) | (wd[15:0] & freep);
                gpr_pkg::REG_SPEED:   n_speed = (r_speed & ~m2) | (wd & m2);
                gpr_pkg::REG_PULL:    n_pull  = (r_pull & ~m2) | (wd & m2);
                gpr_pkg::REG_OUTDATA: n_odata = wd[15:0] & gpr_pkg::VALID_MASK;
                gpr_pkg::REG_SETRESET:
                    n_odata = ((r_odata & ~wd[31:16]) | wd[15:0]) & gpr_pkg::VALID_MASK;
                gpr_pkg::REG_AFL:     n_afl = (r_afl & ~m4[31:0]) | (wd & m4[31:0]);
                gpr_pkg::REG_AFH:     n_afh = (r_afh & ~m4[63:32]) | (wd & m4[63:32]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_otype <= '0;
            r_speed <= '0;
            r_pull  <= '0;
            r_afl   <= '0;
            r_afh   <= '0;
            r_odata <= '0;
        end else begin
            r_mode  <= n_mode;
            r_otype <= n_otype;
            r_speed <= n_speed;
            r_pull  <= n_pull;
            r_afl   <= n_afl;
            r_afh   <= n_afh;
            r_odata <= n_odata;
        end
    end

    always_comb begin
        o_read_data = '0;
        if (i_word.cmd == gpr_pkg::CMD_READ) begin
            unique case (i_word.reg_index)
                gpr_pkg::REG_MODE:    o_read_data = r_mode;
                gpr_pkg::REG_OTYPE:   o_read_data = {16'd0, r_otype};
                gpr_pkg::REG_SPEED:   o_read_data = r_speed;
                gpr_pkg::REG_PULL:    o_read_data = r_pull;
                gpr_pkg::REG_INDATA:
                    o_read_data = {16'd0, i_word.pin_levels & gpr_pkg::VALID_MASK};
                gpr_pkg::REG_OUTDATA: o_read_data = {16'd0, r_odata};
                gpr_pkg::REG_LOCK:
                    o_read_data = {15'd0, i_lock.key_next, i_lock.mask};
                gpr_pkg::REG_AFL:     o_read_data = r_afl;
                gpr_pkg::REG_AFH:     o_read_data = r_afh;
                default:              o_read_data = '0;
            endcase
        end
    end

    assign o_out_data_next = n_odata;

endmodule

@@ design/gpio_port_register_block.sv @@
// GPIO port register block, 16 pins, with bit set/reset and config lock.
// Pipeline: an accepted bus word passes the input register, then the result
// register. Throughput: one bus word per cycle while i_out_ready is high.
// Reset (synchronous, active low) clears every register, the lock and the
// key sequence; both pipeline stages come up empty. Depends on gpr_pkg.
module gpio_port_register_block (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gpr_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gpr_pkg::t_out_word o_out_word
);

    // Input register: holds one bus word until the result register frees up
    logic               r_in_valid;
    gpr_pkg::t_in_word  r_in;
    // Result register
    logic               r_out_valid;
    gpr_pkg::t_out_word r_out;

    logic                advance;
    logic [31:0]         read_data;
    logic [15:0]         out_data_next;
    gpr_pkg::t_lock_req  lock_req;
    gpr_pkg::t_lock_stat lock_stat;

    // Execute the held word when the result register is empty or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    // Take a new word whenever the input register empties this cycle
    assign o_in_ready = !r_in_valid || advance;

    assign lock_req.go    = advance;
    assign lock_req.write = (r_in.cmd == gpr_pkg::CMD_WRITE);
    assign lock_req.hit   = (r_in.reg_index == gpr_pkg::REG_LOCK);
    assign lock_req.key   = r_in.write_data[gpr_pkg::LOCK_KEY_BIT];
    assign lock_req.mask  = r_in.write_data[15:0] & gpr_pkg::VALID_MASK;

    gpr_lock u_lock (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lock_req),
        .o_stat  (lock_stat)
    );

    gpr_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (advance),
        .i_word          (r_in),
        .i_lock          (lock_stat),
        .o_read_data     (read_data),
        .o_out_data_next (out_data_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load the input register on accept, drop it once executed
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            // Load a result on execute, drop it once taken
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out.read_data     <= read_data;
            r_out.output_levels <= out_data_next;
            r_out.lock_active   <= lock_stat.key_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_exec_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("executed word did not reach the result register");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("waiting input word lost or changed");

    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.lock_active |=> r_out.lock_active)
        else $error("lock indication dropped after lock");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the 16-pin GPIO port register block: bus words go in
// through a queued driver, result words are checked against an in-bench port model.
// Depends on gpr_pkg and gpio_port_register_block.
module tb;
    import gpr_pkg::*;

    // Hold off all idling once this few bus words remain to be sent
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 200000;

    // Progress of the lock key sequence
    typedef enum logic [1:0] {
        SEQ_IDLE,   // no key seen
        SEQ_KEY1,   // first write, key set
        SEQ_KEY0,   // second write, key clear, same pins
        SEQ_ARMED   // third write done, a lock read completes the lock
    } t_lock_seq;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word  = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    // Bus words waiting to be driven, and result words waiting to come back
    t_in_word  bus_access_q[$];
    t_out_word pending_response_q[$];

    int total_words    = 0;
    int accepted_words = 0;
    int response_cnt   = 0;
    int bad_cnt        = 0;
    int send_gap       = 0;
    int hold_cnt       = 0;
    int cycle_cnt      = 0;

    // Port model state, all zero out of reset
    logic [31:0] mode_r      = '0;
    logic [15:0] otype_r     = '0;
    logic [31:0] speed_r     = '0;
    logic [31:0] pull_r      = '0;
    logic [31:0] af_lo_r     = '0;
    logic [31:0] af_hi_r     = '0;
    logic [15:0] odata_r     = '0;
    logic [15:0] frozen_pins = '0;
    logic        key_set     = 1'b0;
    t_lock_seq   seq_step    = SEQ_IDLE;

    gpio_port_register_block u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one bus word to the port model and return the result word it causes.
    function automatic t_out_word port_response(input t_in_word w);
        logic [15:0] free_pins;
        logic [15:0] key_pins;
        logic [31:0] m2;
        logic [63:0] m4;
        logic [31:0] rd;
        t_out_word   r;
        // Pins frozen by a completed lock keep their configuration fields
        free_pins = VALID_MASK & ~(key_set ? frozen_pins : 16'h0);
        m2 = '0;
        m4 = '0;
        for (int p = 0; p < 16; p++) begin
            m2[2*p +: 2] = {2{free_pins[p]}};
            m4[4*p +: 4] = {4{free_pins[p]}};
        end
        rd = '0;
        // Any access to another register aborts the key sequence
        if (w.reg_index != REG_LOCK) begin
            seq_step = SEQ_IDLE;
        end
        if (w.cmd == CMD_WRITE) begin
            case (w.reg_index)
                REG_MODE:  mode_r  = (mode_r & ~m2) | (w.write_data & m2);
                REG_OTYPE: otype_r = (otype_r & ~free_pins) | (w.write_data[15:0] & free_pins);
                REG_SPEED: speed_r = (speed_r & ~m2) | (w.write_data & m2);
                REG_PULL:  pull_r  = (pull_r & ~m2) | (w.write_data & m2);
                REG_OUTDATA: odata_r = w.write_data[15:0] & VALID_MASK;
                REG_SETRESET: begin
                    // Clear from the high half first so that set wins
                    odata_r = ((odata_r & ~w.write_data[31:16]) | w.write_data[15:0])
                              & VALID_MASK;
                end
                REG_LOCK: begin
                    key_pins = w.write_data[15:0] & VALID_MASK;
                    if (!key_set) begin
                        if (seq_step == SEQ_KEY1 && !w.write_data[LOCK_KEY_BIT]
                                && key_pins == frozen_pins) begin
                            seq_step = SEQ_KEY0;
                        end else if (seq_step == SEQ_KEY0 && w.write_data[LOCK_KEY_BIT]
                                && key_pins == frozen_pins) begin
                            seq_step = SEQ_ARMED;
                        end else begin
                            // Restart: a key-set write opens a new sequence
                            frozen_pins = key_pins;
                            seq_step = w.write_data[LOCK_KEY_BIT] ? SEQ_KEY1 : SEQ_IDLE;
                        end
                    end
                end
                REG_AFL: af_lo_r = (af_lo_r & ~m4[31:0]) | (w.write_data & m4[31:0]);
                REG_AFH: af_hi_r = (af_hi_r & ~m4[63:32]) | (w.write_data & m4[63:32]);
                default: ;
            endcase
        end else begin
            case (w.reg_index)
                REG_MODE:    rd = mode_r;
                REG_OTYPE:   rd = {16'h0, otype_r};
                REG_SPEED:   rd = speed_r;
                REG_PULL:    rd = pull_r;
                REG_INDATA:  rd = {16'h0, w.pin_levels & VALID_MASK};
                REG_OUTDATA: rd = {16'h0, odata_r};
                REG_LOCK: begin
                    if (seq_step == SEQ_ARMED) begin
                        key_set = 1'b1;
                    end
                    seq_step = SEQ_IDLE;
                    rd = {15'h0, key_set, frozen_pins};
                end
                REG_AFL: rd = af_lo_r;
                REG_AFH: rd = af_hi_r;
                default: rd = '0;
            endcase
        end
        r.read_data     = rd;
        r.output_levels = odata_r;
        r.lock_active   = key_set;
        return r;
    endfunction

    task automatic report_bad(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (bad_cnt < 10) begin
            $display("word %0d: %s expected %h got %h", response_cnt, what, want, got);
        end
        bad_cnt++;
    endtask

    task automatic queue_access(input logic cmd, input logic [3:0] idx,
                                input logic [31:0] data, input logic [15:0] pins);
        t_in_word w;
        w.cmd        = cmd;
        w.reg_index  = idx;
        w.write_data = data;
        w.pin_levels = pins;
        bus_access_q.push_back(w);
    endtask

    // Queue one access to any register but the lock, or to any register at all.
    task automatic queue_plain(input bit with_lock);
        logic [3:0]  idx;
        logic [31:0] data;
        if ($urandom_range(0, 7) == 0) begin
            idx = 4'($urandom_range(10, 15));
        end else begin
            idx = 4'($urandom_range(0, 9));
        end
        if (!with_lock && idx == REG_LOCK) begin
            idx = REG_OUTDATA;
        end
        case ($urandom_range(0, 7))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        queue_access(1'($urandom_range(0, 1)), idx, data, 16'($urandom));
    endtask

    // Mostly plain accesses, the rest key sequences cut off at a random step.
    task automatic queue_traffic(input int n);
        int          stop;
        int          steps;
        logic [15:0] pins;
        stop = bus_access_q.size() + n;
        while (bus_access_q.size() < stop) begin
            if ($urandom_range(0, 4) == 0) begin
                pins  = 16'($urandom) & VALID_MASK;
                steps = $urandom_range(1, 3);
                queue_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b1, pins}, 16'($urandom));
                if (steps > 1) begin
                    queue_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b0, pins},
                                 16'($urandom));
                end
                if (steps > 2) begin
                    queue_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b1, pins},
                                 16'($urandom));
                end
                // Break the sequence before the completing read
                case ($urandom_range(0, 2))
                    0: queue_access(CMD_WRITE, REG_LOCK, $urandom, 16'($urandom));
                    1: begin
                        if (steps < 3) begin
                            queue_access(CMD_READ, REG_LOCK, $urandom, 16'($urandom));
                        end else begin
                            queue_plain(1'b0);
                        end
                    end
                    default: queue_plain(1'b0);
                endcase
            end else begin
                queue_plain(1'b1);
            end
        end
    endtask

    // Driver: advance to the next bus word once the current one is taken,
    // idle in random bursts until the tail of the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pending_response_q.push_back(port_response(i_in_word));
                accepted_words++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (bus_access_q.size() != 0 && (bus_access_q.size() < QUIET_TAIL
                        || $urandom_range(0, 9) != 0)) begin
                    i_in_word  <= bus_access_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    // This cycle idles too and opens a burst that send_gap lengthens
                    if (bus_access_q.size() >= QUIET_TAIL) begin
                        send_gap = $urandom_range(0, 10);
                    end
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result word against the oldest expectation,
    // stall the result side in random bursts until the tail of the run.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_response_q.size() == 0) begin
                    report_bad("unexpected word, read_data", '0, o_out_word.read_data);
                end else begin
                    want = pending_response_q.pop_front();
                    if (o_out_word.read_data !== want.read_data) begin
                        report_bad("read_data", want.read_data, o_out_word.read_data);
                    end
                    if (o_out_word.output_levels !== want.output_levels) begin
                        report_bad("output_levels", 32'(want.output_levels),
                                   32'(o_out_word.output_levels));
                    end
                    if (o_out_word.lock_active !== want.lock_active) begin
                        report_bad("lock_active", 32'(want.lock_active),
                                   32'(o_out_word.lock_active));
                    end
                end
                response_cnt++;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else if (bus_access_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                hold_cnt = $urandom_range(0, 10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [15:0] lock_pins;

        // Directed words: field extremes, most registers, unused index,
        // set-over-clear, and broken key sequences (no lock completes here)
        queue_access(CMD_WRITE, REG_MODE,     32'hFFFF_FFFF, 16'hFFFF);
        queue_access(CMD_READ,  REG_MODE,     32'h0000_0000, 16'h0000);
        queue_access(CMD_WRITE, REG_OTYPE,    32'hFFFF_FFFF, 16'($urandom));
        queue_access(CMD_READ,  REG_OTYPE,    32'hFFFF_FFFF, 16'($urandom));
        queue_access(CMD_READ,  REG_INDATA,   32'h0000_0000, 16'h0000);
        queue_access(CMD_READ,  REG_INDATA,   32'h0000_0000, 16'hFFFF);
        queue_access(CMD_WRITE, REG_INDATA,   32'hFFFF_FFFF, 16'hFFFF);
        queue_access(CMD_WRITE, REG_OUTDATA,  32'hFFFF_FFFF, 16'($urandom));
        queue_access(CMD_WRITE, REG_SETRESET, 32'h0F0F_00FF, 16'($urandom));
        queue_access(CMD_READ,  REG_SETRESET, 32'h0000_0000, 16'($urandom));
        queue_access(CMD_READ,  REG_OUTDATA,  32'h0000_0000, 16'($urandom));
        queue_access(CMD_WRITE, REG_AFH,      32'hFFFF_FFFF, 16'($urandom));
        queue_access(CMD_READ,  REG_AFH,      32'h0000_0000, 16'($urandom));
        queue_access(CMD_WRITE, 4'd15,        32'hFFFF_FFFF, 16'($urandom));
        queue_access(CMD_READ,  4'd15,        32'h0000_0000, 16'($urandom));
        // Access to another register aborts after the second key write
        queue_access(CMD_WRITE, REG_LOCK,     32'h0001_00A5, 16'($urandom));
        queue_access(CMD_WRITE, REG_LOCK,     32'h0000_00A5, 16'($urandom));
        queue_access(CMD_READ,  REG_OTYPE,    32'h0000_0000, 16'($urandom));
        // Different pins abort
        queue_access(CMD_WRITE, REG_LOCK,     32'h0001_1234, 16'($urandom));
        queue_access(CMD_WRITE, REG_LOCK,     32'h0000_4321, 16'($urandom));
        // Extra key write after the third restarts; early lock read aborts
        queue_access(CMD_WRITE, REG_LOCK,     32'hFFFF_FFFF, 16'($urandom));
        queue_access(CMD_WRITE, REG_LOCK,     32'hFFFE_FFFF, 16'($urandom));
        queue_access(CMD_WRITE, REG_LOCK,     32'h0001_FFFF, 16'($urandom));
        queue_access(CMD_WRITE, REG_LOCK,     32'h0001_FFFF, 16'($urandom));
        queue_access(CMD_READ,  REG_LOCK,     32'h0000_0000, 16'($urandom));

        queue_traffic(1230);

        // Complete the lock on a random pin set, then keep hammering the
        // frozen fields, ignored lock writes and lock reads
        lock_pins = 16'($urandom) & VALID_MASK;
        queue_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b1, lock_pins}, 16'($urandom));
        queue_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b0, lock_pins}, 16'($urandom));
        queue_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b1, lock_pins}, 16'($urandom));
        queue_access(CMD_READ,  REG_LOCK, 32'h0000_0000, 16'($urandom));

        queue_traffic(300);
        total_words = bus_access_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_words != total_words) @(posedge i_clk);
        while (pending_response_q.size() != 0) @(posedge i_clk);
        // Catch any stray word past the two-stage latency
        repeat (8) @(posedge i_clk);

        if (pending_response_q.size() != 0) begin
            report_bad("words never returned", 32'(pending_response_q.size()), '0);
        end
        if (bad_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/gpr_pkg.sv
design/gpr_lock.sv
design/gpr_regs.sv
design/gpio_port_register_block.sv
tb/tb.sv
